### hdl/rmx_pkg.sv
// Shared codes for the range argmax segment tree.
// No dependencies; used by range_argmax_segment_tree and rmx_pick.
package rmx_pkg;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef enum logic {
      SIDE_LEFT  = 1'b0,
      SIDE_RIGHT = 1'b1
   } side_type;

endpackage

### hdl/range_argmax_segment_tree.sv
// Top level of the range argmax segment tree: sequencer, bounds register and two memories.
// Depends on rmx_pkg, rmx_ram and rmx_pick.
//
//   channel   ports                                   handshake
//   request   req_command req_index_lo req_index_hi   start, accepted when busy is low
//             req_new_value
//   response  rsp_max_index rsp_status                rsp_valid, one cycle, no stall
//   config    csr_wr_data                             csr_wr_en, taken at any edge
//
// After reset a clearing pass writes every address of both memories; busy is high.
// An update walks up the tree, per level a winner read (skipped for a leaf sibling), a value
// read and a combine, in that order because each memory has one read port.
// A query visits up to two nodes per level; each node takes a winner read (skipped for a leaf),
// a value read and a combine, and each level adds a move up. An error answers from decode.
// The response cannot be stalled; busy falls with rsp_valid and the next request may follow.
module range_argmax_segment_tree #(
   parameter int MAX_ENTRIES = 1024,
   parameter int VALUE_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_command,
   input  logic [$clog2(MAX_ENTRIES)-1:0]       req_index_lo,
   input  logic [$clog2(MAX_ENTRIES)-1:0]       req_index_hi,
   input  logic signed [VALUE_BITS-1:0]         req_new_value,
   output logic                                 rsp_valid,
   output logic [$clog2(MAX_ENTRIES)-1:0]       rsp_max_index,
   output logic                                 rsp_status,
   input  logic                                 csr_wr_en,
   input  logic [$clog2(MAX_ENTRIES):0]         csr_wr_data
);

   localparam int L = $clog2(MAX_ENTRIES);
   localparam logic [L:0]   P_NODE = {1'b1, {L{1'b0}}};
   localparam logic [L:0]   BOUND_MAX = (L+1)'(MAX_ENTRIES);

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_DECODE  = 4'd2;
   localparam logic [3:0] ST_FETCH_W = 4'd3;
   localparam logic [3:0] ST_FETCH_V = 4'd4;
   localparam logic [3:0] ST_COMBINE = 4'd5;
   localparam logic [3:0] ST_NEXT    = 4'd6;
   localparam logic [3:0] ST_FINISH  = 4'd7;

   function automatic logic [L-1:0] first_leaf(input logic [L-1:0] n);
      logic [2*L-1:0] t;
      t = '0;
      for (int k = 0; k < L; k++) begin
         if (n[k]) begin
            t = {n, {L{1'b0}}} >> k;
         end
      end
      return t[L-1:0];
   endfunction

   logic [3:0]                   state_ff, state_in;
   logic [L-1:0]                 clr_ff, clr_in;
   logic [L:0]                   csr_ff, csr_in;
   logic                         cmd_ff, cmd_in;
   logic [L-1:0]                 lo_ff, lo_in;
   logic [L-1:0]                 hi_ff, hi_in;
   logic signed [VALUE_BITS-1:0] val_ff, val_in;
   logic [L:0]                   node_ff, node_in;
   logic [L:0]                   child_ff, child_in;
   logic [L+1:0]                 l_ff, l_in;
   logic [L+1:0]                 r_ff, r_in;
   rmx_pkg::side_type            side_ff, side_in;
   logic [L-1:0]                 cand_ff, cand_in;
   logic [L-1:0]                 accl_idx_ff, accl_idx_in;
   logic signed [VALUE_BITS-1:0] accl_val_ff, accl_val_in;
   logic                         accl_v_ff, accl_v_in;
   logic [L-1:0]                 accr_idx_ff, accr_idx_in;
   logic signed [VALUE_BITS-1:0] accr_val_ff, accr_val_in;
   logic                         accr_v_ff, accr_v_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [L-1:0]                 rsp_idx_ff, rsp_idx_in;
   logic                         rsp_status_ff, rsp_status_in;

   logic [L:0]                   bound;
   logic [L:0]                   parent;
   logic                         vmem_we;
   logic [L-1:0]                 vmem_wa;
   logic [VALUE_BITS-1:0]        vmem_wd;
   logic [L-1:0]                 vmem_ra;
   logic [VALUE_BITS-1:0]        vmem_rd;
   logic                         wmem_we;
   logic [L-1:0]                 wmem_wa;
   logic [L-1:0]                 wmem_wd;
   logic [L-1:0]                 wmem_rd;
   logic [L-1:0]                 cand_now;
   logic signed [VALUE_BITS-1:0] cand_val;
   logic [L-1:0]                 pk_a_idx, pk_b_idx, pk_idx;
   logic signed [VALUE_BITS-1:0] pk_a_val, pk_b_val, pk_val;

   assign bound    = (csr_ff > BOUND_MAX) ? BOUND_MAX : csr_ff;
   assign parent   = child_ff >> 1;
   assign cand_now = node_ff[L] ? node_ff[L-1:0] : wmem_rd;
   assign cand_val = $signed(vmem_rd);

   rmx_ram #(
      .ADDR_BITS (L),
      .DATA_BITS (VALUE_BITS)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (vmem_we),
      .wr_addr (vmem_wa),
      .wr_data (vmem_wd),
      .rd_addr (vmem_ra),
      .rd_data (vmem_rd)
   );

   rmx_ram #(
      .ADDR_BITS (L),
      .DATA_BITS (L)
   ) u_winner_ram (
      .clock   (clock),
      .wr_en   (wmem_we),
      .wr_addr (wmem_wa),
      .wr_data (wmem_wd),
      .rd_addr (node_ff[L-1:0]),
      .rd_data (wmem_rd)
   );

   rmx_pick #(
      .IDX_BITS   (L),
      .VALUE_BITS (VALUE_BITS)
   ) u_pick (
      .a_idx   (pk_a_idx),
      .a_val   (pk_a_val),
      .b_idx   (pk_b_idx),
      .b_val   (pk_b_val),
      .win_idx (pk_idx),
      .win_val (pk_val)
   );

   always_comb begin
      pk_a_idx = accl_idx_ff;
      pk_a_val = accl_val_ff;
      pk_b_idx = accr_idx_ff;
      pk_b_val = accr_val_ff;
      if (state_ff == ST_COMBINE) begin
         if (cmd_ff == rmx_pkg::CMD_UPDATE) begin
            if (node_ff[0]) begin
               pk_b_idx = cand_ff;
               pk_b_val = cand_val;
            end else begin
               pk_a_idx = cand_ff;
               pk_a_val = cand_val;
               pk_b_idx = accl_idx_ff;
               pk_b_val = accl_val_ff;
            end
         end else if (side_ff == rmx_pkg::SIDE_LEFT) begin
            pk_b_idx = cand_ff;
            pk_b_val = cand_val;
         end else begin
            pk_a_idx = cand_ff;
            pk_a_val = cand_val;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      csr_in        = csr_wr_en ? csr_wr_data : csr_ff;
      cmd_in        = cmd_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      val_in        = val_ff;
      node_in       = node_ff;
      child_in      = child_ff;
      l_in          = l_ff;
      r_in          = r_ff;
      side_in       = side_ff;
      cand_in       = cand_ff;
      accl_idx_in   = accl_idx_ff;
      accl_val_in   = accl_val_ff;
      accl_v_in     = accl_v_ff;
      accr_idx_in   = accr_idx_ff;
      accr_val_in   = accr_val_ff;
      accr_v_in     = accr_v_ff;
      rsp_valid_in  = 1'b0;
      rsp_idx_in    = rsp_idx_ff;
      rsp_status_in = rsp_status_ff;
      vmem_we       = 1'b0;
      vmem_wa       = lo_ff;
      vmem_wd       = val_ff;
      vmem_ra       = cand_now;
      wmem_we       = 1'b0;
      wmem_wa       = parent[L-1:0];
      wmem_wd       = pk_idx;

      case (state_ff)
         ST_CLEAR: begin
            vmem_we = 1'b1;
            vmem_wa = clr_ff;
            vmem_wd = '0;
            wmem_we = 1'b1;
            wmem_wa = clr_ff;
            wmem_wd = first_leaf(clr_ff);
            clr_in  = clr_ff + L'(1);
            if (clr_ff == {L{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_command;
               lo_in    = req_index_lo;
               hi_in    = req_index_hi;
               val_in   = req_new_value;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            accl_v_in = 1'b0;
            accr_v_in = 1'b0;
            if (cmd_ff == rmx_pkg::CMD_UPDATE) begin
               if ({1'b0, lo_ff} >= bound) begin
                  rsp_valid_in  = 1'b1;
                  rsp_idx_in    = '0;
                  rsp_status_in = rmx_pkg::STATUS_ERROR;
                  state_in      = ST_IDLE;
               end else begin
                  vmem_we     = 1'b1;
                  accl_idx_in = lo_ff;
                  accl_val_in = val_ff;
                  child_in    = P_NODE | {1'b0, lo_ff};
                  node_in     = (P_NODE | {1'b0, lo_ff}) ^ (L+1)'(1);
                  state_in    = ST_FETCH_V;
               end
            end else begin
               if ({1'b0, hi_ff} >= bound || lo_ff > hi_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_idx_in    = '0;
                  rsp_status_in = rmx_pkg::STATUS_ERROR;
                  state_in      = ST_IDLE;
               end else begin
                  l_in     = {1'b0, P_NODE} + {2'b00, lo_ff};
                  r_in     = {1'b0, P_NODE} + {2'b00, hi_ff} + (L+2)'(1);
                  state_in = ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            if (l_ff >= r_ff) begin
               state_in = ST_FINISH;
            end else if (l_ff[0]) begin
               node_in  = l_ff[L:0];
               side_in  = rmx_pkg::SIDE_LEFT;
               l_in     = l_ff + (L+2)'(1);
               state_in = l_ff[L] ? ST_FETCH_V : ST_FETCH_W;
            end else if (r_ff[0]) begin
               node_in  = r_ff[L:0] - (L+1)'(1);
               side_in  = rmx_pkg::SIDE_RIGHT;
               r_in     = r_ff - (L+2)'(1);
               state_in = r_ff[L] ? ST_FETCH_V : ST_FETCH_W;
            end else begin
               l_in = l_ff >> 1;
               r_in = r_ff >> 1;
            end
         end
         ST_FETCH_W: begin
            state_in = ST_FETCH_V;
         end
         ST_FETCH_V: begin
            cand_in  = cand_now;
            state_in = ST_COMBINE;
         end
         ST_COMBINE: begin
            if (cmd_ff == rmx_pkg::CMD_UPDATE) begin
               wmem_we     = 1'b1;
               accl_idx_in = pk_idx;
               accl_val_in = pk_val;
               if (parent == (L+1)'(1)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_idx_in    = '0;
                  rsp_status_in = rmx_pkg::STATUS_OK;
                  state_in      = ST_IDLE;
               end else begin
                  child_in = parent;
                  node_in  = parent ^ (L+1)'(1);
                  state_in = ST_FETCH_W;
               end
            end else begin
               if (side_ff == rmx_pkg::SIDE_LEFT) begin
                  accl_idx_in = accl_v_ff ? pk_idx : cand_ff;
                  accl_val_in = accl_v_ff ? pk_val : cand_val;
                  accl_v_in   = 1'b1;
               end else begin
                  accr_idx_in = accr_v_ff ? pk_idx : cand_ff;
                  accr_val_in = accr_v_ff ? pk_val : cand_val;
                  accr_v_in   = 1'b1;
               end
               state_in = ST_NEXT;
            end
         end
         ST_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = rmx_pkg::STATUS_OK;
            if (accl_v_ff && accr_v_ff) begin
               rsp_idx_in = pk_idx;
            end else if (accl_v_ff) begin
               rsp_idx_in = accl_idx_ff;
            end else begin
               rsp_idx_in = accr_idx_ff;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         csr_ff       <= BOUND_MAX;
         accl_v_ff    <= 1'b0;
         accr_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         csr_ff       <= csr_in;
         accl_v_ff    <= accl_v_in;
         accr_v_ff    <= accr_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      val_ff        <= val_in;
      node_ff       <= node_in;
      child_ff      <= child_in;
      l_ff          <= l_in;
      r_ff          <= r_in;
      side_ff       <= side_in;
      cand_ff       <= cand_in;
      accl_idx_ff   <= accl_idx_in;
      accl_val_ff   <= accl_val_in;
      accr_idx_ff   <= accr_idx_in;
      accr_val_ff   <= accr_val_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_index = rsp_idx_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

### hdl/rmx_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
// No dependencies; holds leaf values and node winners of the tree.
module rmx_ram #(
   parameter int ADDR_BITS = 10,
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/rmx_pick.sv
// Leftmost-wins maximum of two candidates, each an index and its signed value.
// Depends on rmx_pkg for the side encoding used by its tie rule.
module rmx_pick #(
   parameter int IDX_BITS   = 10,
   parameter int VALUE_BITS = 32
) (
   input  logic [IDX_BITS-1:0]          a_idx,
   input  logic signed [VALUE_BITS-1:0] a_val,
   input  logic [IDX_BITS-1:0]          b_idx,
   input  logic signed [VALUE_BITS-1:0] b_val,
   output logic [IDX_BITS-1:0]          win_idx,
   output logic signed [VALUE_BITS-1:0] win_val
);

   rmx_pkg::side_type take;

   // Operand a is the left one, so it keeps a tie.
   assign take    = (a_val < b_val) ? rmx_pkg::SIDE_RIGHT : rmx_pkg::SIDE_LEFT;
   assign win_idx = (take == rmx_pkg::SIDE_RIGHT) ? b_idx : a_idx;
   assign win_val = (take == rmx_pkg::SIDE_RIGHT) ? b_val : a_val;

endmodule
